FILE: hdl/sha1_pkg.sv
// Shared types and constants for the SHA-1 byte-stream hasher.
`default_nettype none
package sha1_pkg;

   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

   localparam logic [31:0] K_ROUND0 = 32'h5A827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [6:0] ROUND_LAST = 7'd79;
   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [5:0] FILL_LEN_START = 6'd56;
   localparam logic [2:0] WORD_LAST = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_UPDATE,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      SEL_DATA,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         shift_en;
      byte_sel_type byte_sel;
      logic         count_bits;
      logic         load_work;
      logic         round_en;
      logic         update_h;
      logic         out_next;
      logic         restart;
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       round_last;
      logic       out_last;
   } status_type;

endpackage
`default_nettype wire

FILE: hdl/sha1_ctrl.sv
// Controller state machine: byte intake, padding sequence, compression and digest output.
`default_nettype none
module sha1_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_byte_valid,
   input  wire                  req_finish,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   input  sha1_pkg::status_type status,
   output sha1_pkg::cmd_type    cmd
);
   import sha1_pkg::*;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      cmd       = '0;
      cmd.byte_sel = SEL_DATA;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_byte_valid) begin
                  cmd.shift_en   = 1'b1;
                  cmd.byte_sel   = SEL_DATA;
                  cmd.count_bits = 1'b1;
               end
               if (req_byte_valid && status.fill == FILL_LAST) begin
                  // The block is full: compress it before anything else.
                  cmd.load_work = 1'b1;
                  state_in      = ST_ROUND;
                  ret_in        = req_finish ? ST_PAD_MARK : ST_IDLE;
               end else if (req_finish) begin
                  state_in = ST_PAD_MARK;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (status.round_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update_h = 1'b1;
            state_in     = ret_ff;
         end
         ST_PAD_MARK: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = SEL_MARK;
            if (status.fill == FILL_LAST) begin
               cmd.load_work = 1'b1;
               state_in      = ST_ROUND;
               ret_in        = ST_PAD_ZERO;
            end else begin
               state_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            if (status.fill == FILL_LEN_START) begin
               state_in = ST_PAD_LEN;
            end else begin
               cmd.shift_en = 1'b1;
               cmd.byte_sel = SEL_ZERO;
               if (status.fill == FILL_LAST) begin
                  // The marker did not leave room for the length: one extra block.
                  cmd.load_work = 1'b1;
                  state_in      = ST_ROUND;
                  ret_in        = ST_PAD_ZERO;
               end
            end
         end
         ST_PAD_LEN: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = SEL_LEN;
            if (status.fill == FILL_LAST) begin
               cmd.load_work = 1'b1;
               state_in      = ST_ROUND;
               ret_in        = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.out_next = 1'b1;
               if (status.out_last) begin
                  cmd.restart = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: hdl/sha1_dp.sv
// Datapath: message window, round registers, chaining words and bit count.
`default_nettype none
module sha1_dp (
   input  wire                   clock,
   input  wire                   reset,
   input  wire  [7:0]            req_data_byte,
   input  sha1_pkg::cmd_type     cmd,
   output sha1_pkg::status_type  status,
   output logic [31:0]           rsp_digest_word,
   output logic [2:0]            rsp_word_index,
   output logic                  rsp_last_word
);
   import sha1_pkg::*;

   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [31:0] h_ff   [5];
   logic [31:0] h_in   [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [6:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;

   logic [7:0]  new_byte;
   logic [63:0] len_shifted;
   logic [31:0] sched_word;
   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] t_val;

   // The length goes out big-endian: fill 56 takes bits 63..56.
   assign len_shifted = bits_ff >> {~fill_ff[2:0], 3'b000};

   always_comb begin
      case (cmd.byte_sel)
         SEL_DATA: new_byte = req_data_byte;
         SEL_MARK: new_byte = PAD_MARK;
         SEL_ZERO: new_byte = 8'h00;
         default:  new_byte = len_shifted[7:0];
      endcase
   end

   assign sched_word = (win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0]);

   always_comb begin
      if (round_ff < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K_ROUND0;
      end else if (round_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_ROUND1;
      end else if (round_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K_ROUND2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_ROUND3;
      end
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + win_ff[0];

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         win_in[i] = win_ff[i];
      end
      if (cmd.shift_en) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = {win_ff[i][23:0], win_ff[i+1][31:24]};
         end
         win_in[15] = {win_ff[15][23:0], new_byte};
      end else if (cmd.round_en) begin
         // The window holds w[i] .. w[i+15]; the oldest word drops out.
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[15] = {sched_word[30:0], sched_word[31]};
      end
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      round_in = round_ff;
      if (cmd.load_work) begin
         a_in     = h_ff[0];
         b_in     = h_ff[1];
         c_in     = h_ff[2];
         d_in     = h_ff[3];
         e_in     = h_ff[4];
         round_in = 7'd0;
      end else if (cmd.round_en) begin
         a_in     = t_val;
         b_in     = a_ff;
         c_in     = {b_ff[1:0], b_ff[31:2]};
         d_in     = c_ff;
         e_in     = d_ff;
         round_in = round_ff + 7'd1;
      end
   end

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         h_in[i] = h_ff[i];
      end
      fill_in = fill_ff;
      bits_in = bits_ff;
      idx_in  = idx_ff;
      if (cmd.restart) begin
         h_in[0] = H0_INIT;
         h_in[1] = H1_INIT;
         h_in[2] = H2_INIT;
         h_in[3] = H3_INIT;
         h_in[4] = H4_INIT;
         fill_in = 6'd0;
         bits_in = 64'd0;
         idx_in  = 3'd0;
      end else begin
         if (cmd.update_h) begin
            h_in[0] = h_ff[0] + a_ff;
            h_in[1] = h_ff[1] + b_ff;
            h_in[2] = h_ff[2] + c_ff;
            h_in[3] = h_ff[3] + d_ff;
            h_in[4] = h_ff[4] + e_ff;
         end
         if (cmd.shift_en) begin
            fill_in = fill_ff + 6'd1;
         end
         if (cmd.count_bits) begin
            bits_in = bits_ff + 64'd8;
         end
         if (cmd.out_next) begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff[0]  <= H0_INIT;
         h_ff[1]  <= H1_INIT;
         h_ff[2]  <= H2_INIT;
         h_ff[3]  <= H3_INIT;
         h_ff[4]  <= H4_INIT;
         fill_ff  <= 6'd0;
         bits_ff  <= 64'd0;
         idx_ff   <= 3'd0;
         round_ff <= 7'd0;
      end else begin
         for (int i = 0; i < 5; i++) begin
            h_ff[i] <= h_in[i];
         end
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         idx_ff   <= idx_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         win_ff[i] <= win_in[i];
      end
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

   assign status.fill       = fill_ff;
   assign status.round_last = (round_ff == ROUND_LAST);
   assign status.out_last   = (idx_ff == WORD_LAST);

   assign rsp_digest_word = h_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == WORD_LAST);

endmodule
`default_nettype wire

FILE: hdl/sha1_digest.sv
// SHA-1 hasher top level: one message byte per transaction, five digest words out.
//
// The request channel carries one byte per transaction (req_byte_valid) and an
// optional finish flag that pads the message and produces the digest after that
// transaction's byte. A transaction with neither flag set changes nothing.
// Plain byte transactions are taken at one per cycle. The 64th byte of a block
// starts a compression that holds req_stall high through 80 rounds at one round
// per cycle and then the chaining update, so sustained intake is set by the
// single round unit. A finish shifts in the 0x80 marker, zero fill and the
// 64-bit length one byte per cycle outside the compressions, with one or two
// compressions before the first digest word.
// The digest leaves on the response channel as five transactions, word index 0
// to 4, most significant word first, with rsp_last_word on the fifth. While
// rsp_stall is high the current word holds and no new request is taken. After
// the fifth word the hasher returns to its initial chaining values for the next
// message. Synchronous reset puts it in the same start state, ready at once.
`default_nettype none
module sha1_digest (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_byte_valid,
   input  wire         req_finish,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha1_pkg::*;

   cmd_type    cmd;
   status_type status;

   sha1_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_byte_valid (req_byte_valid),
      .req_finish     (req_finish),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .cmd            (cmd)
   );

   sha1_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_data_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

endmodule
`default_nettype wire
